@@ rtl/ptt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, types and helpers for the periodic task timer bank.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int SLOTS        = 8;
   localparam int TICKS_PER_MS = 2;
   localparam int BASE_RATE    = 2000;
   localparam int ADDR_SLOTS   = 8;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = 24 + $clog2(TICKS_PER_MS);
   localparam int REM_W  = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
   localparam int FIRE_W = (SLOTS < ADDR_SLOTS) ? SLOTS : ADDR_SLOTS;

   localparam logic [CNT_W-1:0] RELOAD_RESET = CNT_W'(BASE_RATE * TICKS_PER_MS);
   localparam logic [7:0]       EVENT_MAX    = 8'd255;

   typedef enum logic [2:0] {
      KIND_TICK   = 3'd0,
      KIND_ALLOC  = 3'd1,
      KIND_SET    = 3'd2,
      KIND_READ   = 3'd3,
      KIND_CLEAR  = 3'd4,
      KIND_TIME   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TICK,
      OP_ALLOC,
      OP_SET,
      OP_READ,
      OP_CLEAR,
      OP_TIME
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   // slot field to array index, zero-extended or truncated to the bank depth
   function automatic logic [IDX_W-1:0] to_idx(input logic [2:0] s);
      logic [IDX_W+2:0] wide;
      wide = {{IDX_W{1'b0}}, s};
      return wide[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/ptt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl
// Handshake controller: decodes the request kind into a datapath command and
// tracks the occupancy of the response register.
// ----------------------------------------------------------------------------
module ptt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_kind,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ptt_pkg::cmd_type      cmd
);

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   ptt_pkg::op_type op;

   assign rsp_valid = (state_ff == ST_FULL);
   // the response register frees up in the same cycle its beat is taken
   assign req_stall = (state_ff == ST_FULL) && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unique case (ptt_pkg::kind_type'(req_kind))
         ptt_pkg::KIND_TICK:  op = ptt_pkg::OP_TICK;
         ptt_pkg::KIND_ALLOC: op = ptt_pkg::OP_ALLOC;
         ptt_pkg::KIND_SET:   op = ptt_pkg::OP_SET;
         ptt_pkg::KIND_READ:  op = ptt_pkg::OP_READ;
         ptt_pkg::KIND_CLEAR: op = ptt_pkg::OP_CLEAR;
         ptt_pkg::KIND_TIME:  op = ptt_pkg::OP_TIME;
         default:             op = ptt_pkg::OP_NONE;
      endcase
   end

   assign cmd.load = accept;
   assign cmd.op   = op;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_FULL;
      end else if (!rsp_stall) begin
         state_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/ptt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_datapath
// Slot bank state, tick time counters and the response register.
// ----------------------------------------------------------------------------
module ptt_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ptt_pkg::cmd_type cmd,
   input  wire logic [2:0]       req_slot,
   input  wire logic [23:0]      req_period_ms,
   output logic [2:0]            rsp_slot_out,
   output logic                  rsp_ok,
   output logic [7:0]            rsp_flag_count,
   output logic [62:0]           rsp_time_ms,
   output logic [7:0]            rsp_fire_mask
);

   localparam int CW = ptt_pkg::CNT_W;
   localparam int RW = ptt_pkg::REM_W;
   localparam int IW = ptt_pkg::IDX_W;

   logic          in_use_ff [ptt_pkg::SLOTS];
   logic          in_use_in [ptt_pkg::SLOTS];
   logic [CW-1:0] reload_ff [ptt_pkg::SLOTS];
   logic [CW-1:0] reload_in [ptt_pkg::SLOTS];
   logic [CW-1:0] down_ff   [ptt_pkg::SLOTS];
   logic [CW-1:0] down_in   [ptt_pkg::SLOTS];
   logic [7:0]    event_ff  [ptt_pkg::SLOTS];
   logic [7:0]    event_in  [ptt_pkg::SLOTS];

   logic [63:0]   tick_time_ff, tick_time_in;
   logic [63:0]   ms_ff, ms_in;
   logic [RW-1:0] rem_ff, rem_in;

   logic [2:0]    slot_out_ff, slot_out_in;
   logic          ok_ff, ok_in;
   logic [7:0]    flag_ff, flag_in;
   logic [62:0]   time_ff, time_in;
   logic [7:0]    fire_ff, fire_in;

   logic          slot_ok;
   logic [IW-1:0] slot_idx;
   logic [CW-1:0] ticks;
   logic          alloc_hit;
   logic [IW-1:0] alloc_idx;
   logic [2:0]    alloc_num;
   logic [7:0]    fire_v;

   assign slot_ok  = ({3'b000, req_slot} < 6'(ptt_pkg::SLOTS));
   assign slot_idx = ptt_pkg::to_idx(req_slot);
   assign ticks    = CW'(req_period_ms) * CW'(ptt_pkg::TICKS_PER_MS);

   // lowest free slot among those the response can name
   always_comb begin
      alloc_hit = 1'b0;
      alloc_idx = '0;
      alloc_num = '0;
      for (int i = ptt_pkg::FIRE_W - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            alloc_hit = 1'b1;
            alloc_idx = IW'(i);
            alloc_num = 3'(i);
         end
      end
   end

   always_comb begin
      fire_v = '0;
      for (int i = 0; i < ptt_pkg::FIRE_W; i++) begin
         fire_v[i] = in_use_ff[i] && (down_ff[i] == '0);
      end
   end

   always_comb begin
      in_use_in    = in_use_ff;
      reload_in    = reload_ff;
      down_in      = down_ff;
      event_in     = event_ff;
      tick_time_in = tick_time_ff;
      ms_in        = ms_ff;
      rem_in       = rem_ff;
      slot_out_in  = '0;
      ok_in        = 1'b0;
      flag_in      = '0;
      time_in      = '0;
      fire_in      = '0;
      if (cmd.load) begin
         unique case (cmd.op)
            ptt_pkg::OP_TICK: begin
               for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
                  if (down_ff[i] != '0) begin
                     down_in[i] = down_ff[i] - CW'(1);
                  end else begin
                     down_in[i] = reload_ff[i];
                     if (event_ff[i] != ptt_pkg::EVENT_MAX) begin
                        event_in[i] = event_ff[i] + 8'd1;
                     end
                  end
               end
               tick_time_in = tick_time_ff + 64'd1;
               // quotient tracked alongside, restarting when tick time wraps
               if (tick_time_ff == '1) begin
                  ms_in  = '0;
                  rem_in = '0;
               end else if (rem_ff == RW'(ptt_pkg::TICKS_PER_MS - 1)) begin
                  ms_in  = ms_ff + 64'd1;
                  rem_in = '0;
               end else begin
                  rem_in = rem_ff + RW'(1);
               end
               fire_in = fire_v;
               ok_in   = 1'b1;
            end
            ptt_pkg::OP_ALLOC: begin
               if (alloc_hit) begin
                  in_use_in[alloc_idx] = 1'b1;
                  reload_in[alloc_idx] = ticks;
                  down_in[alloc_idx]   = ticks;
                  event_in[alloc_idx]  = '0;
                  slot_out_in          = alloc_num;
                  ok_in                = 1'b1;
               end
            end
            ptt_pkg::OP_SET: begin
               if (slot_ok) begin
                  reload_in[slot_idx] = ticks;
                  down_in[slot_idx]   = ticks;
                  event_in[slot_idx]  = '0;
                  ok_in               = 1'b1;
               end
            end
            ptt_pkg::OP_READ: begin
               if (slot_ok) begin
                  flag_in = event_ff[slot_idx];
                  ok_in   = 1'b1;
               end
            end
            ptt_pkg::OP_CLEAR: begin
               if (slot_ok) begin
                  event_in[slot_idx] = '0;
                  ok_in              = 1'b1;
               end
            end
            ptt_pkg::OP_TIME: begin
               time_in = ms_ff[62:0];
               ok_in   = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
            in_use_ff[i] <= 1'b0;
            reload_ff[i] <= ptt_pkg::RELOAD_RESET;
            down_ff[i]   <= '0;
            event_ff[i]  <= '0;
         end
         tick_time_ff <= '0;
         ms_ff        <= '0;
         rem_ff       <= '0;
      end else begin
         in_use_ff    <= in_use_in;
         reload_ff    <= reload_in;
         down_ff      <= down_in;
         event_ff     <= event_in;
         tick_time_ff <= tick_time_in;
         ms_ff        <= ms_in;
         rem_ff       <= rem_in;
      end
   end

   // response register, loaded once per accepted beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_out_ff <= slot_out_in;
         ok_ff       <= ok_in;
         flag_ff     <= flag_in;
         time_ff     <= time_in;
         fire_ff     <= fire_in;
      end
   end

   assign rsp_slot_out   = slot_out_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_flag_count = flag_ff;
   assign rsp_time_ms    = time_ff;
   assign rsp_fire_mask  = fire_ff;

endmodule
`default_nettype wire

@@ rtl/periodic_task_timer_bank.sv @@
`default_nettype none
// latency: a response is valid in the cycle after its request beat is accepted
// throughput: one request per cycle unless a held response is stalled, set by
//   the single response register, which reloads in the same cycle its beat is taken
// reset clears all slots to free with period 4000 ticks, counters, event
//   counts and tick time to zero; no response is pending after reset
// ----------------------------------------------------------------------------
// periodic_task_timer_bank
// Bank of periodic timer slots driven by tick, allocate, set period, flag
// and time requests.
// ----------------------------------------------------------------------------
module periodic_task_timer_bank (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [2:0]  req_slot,
   input  wire logic [23:0] req_period_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_slot_out,
   output logic             rsp_ok,
   output logic [7:0]       rsp_flag_count,
   output logic [62:0]      rsp_time_ms,
   output logic [7:0]       rsp_fire_mask
);

   ptt_pkg::cmd_type cmd;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ptt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_slot       (req_slot),
      .req_period_ms  (req_period_ms),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_ok         (rsp_ok),
      .rsp_flag_count (rsp_flag_count),
      .rsp_time_ms    (rsp_time_ms),
      .rsp_fire_mask  (rsp_fire_mask)
   );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic task timer bank. Requests are driven
// on the falling edge with random gaps and the response side stalls at
// random. A cycle-free copy of the slot bank predicts every response, and
// each response beat is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  slot_out;
      logic        ok;
      logic [7:0]  flag_count;
      logic [62:0] time_ms;
      logic [7:0]  fire_mask;
   } timer_reply_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [2:0]  req_slot;
   logic [23:0] req_period_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_slot_out;
   logic        rsp_ok;
   logic [7:0]  rsp_flag_count;
   logic [62:0] rsp_time_ms;
   logic [7:0]  rsp_fire_mask;

   // shadow copy of the slot bank
   bit                        slot_busy [ptt_pkg::SLOTS];
   logic [ptt_pkg::CNT_W-1:0] slot_period [ptt_pkg::SLOTS];
   logic [ptt_pkg::CNT_W-1:0] slot_count [ptt_pkg::SLOTS];
   logic [7:0]                slot_events [ptt_pkg::SLOTS];
   logic [63:0]               elapsed_ticks;

   timer_reply_type pending_replies[$];

   bit quiet;
   int fail_count;
   int requests_taken;
   int replies_checked;
   int ticks_seen;
   int grants_seen;
   int saturated_reads;

   periodic_task_timer_bank i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_slot       (req_slot),
      .req_period_ms  (req_period_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_ok         (rsp_ok),
      .rsp_flag_count (rsp_flag_count),
      .rsp_time_ms    (rsp_time_ms),
      .rsp_fire_mask  (rsp_fire_mask)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [ptt_pkg::CNT_W-1:0] ms_to_ticks(input logic [23:0] ms);
      logic [31:0] wide;
      wide = 32'(ms) * 32'(ptt_pkg::TICKS_PER_MS);
      return wide[ptt_pkg::CNT_W-1:0];
   endfunction

   function automatic void reset_timer_bank();
      for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
         slot_busy[i]   = 1'b0;
         slot_period[i] = ptt_pkg::CNT_W'(ptt_pkg::BASE_RATE * ptt_pkg::TICKS_PER_MS);
         slot_count[i]  = '0;
         slot_events[i] = '0;
      end
      elapsed_ticks = '0;
   endfunction

   function automatic void program_slot(input int s, input logic [23:0] ms);
      slot_period[s] = ms_to_ticks(ms);
      slot_count[s]  = slot_period[s];
      slot_events[s] = '0;
   endfunction

   // applies one request to the shadow bank and returns the response it causes
   function automatic timer_reply_type timer_bank_step(input logic [2:0] kind,
                                                       input logic [2:0] slot,
                                                       input logic [23:0] ms);
      timer_reply_type r;
      bit granted;
      r = '{slot_out: '0, ok: 1'b0, flag_count: '0, time_ms: '0, fire_mask: '0};
      granted = 1'b0;
      case (kind)
         ptt_pkg::KIND_TICK: begin
            for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
               if (slot_count[i] != '0) begin
                  slot_count[i] = slot_count[i] - 1'b1;
               end else begin
                  slot_count[i] = slot_period[i];
                  if (slot_events[i] != ptt_pkg::EVENT_MAX) begin
                     slot_events[i] = slot_events[i] + 1'b1;
                  end
                  if (slot_busy[i] && i < ptt_pkg::ADDR_SLOTS && i < 8) begin
                     r.fire_mask[i] = 1'b1;
                  end
               end
            end
            elapsed_ticks = elapsed_ticks + 1'b1;
            r.ok = 1'b1;
            ticks_seen++;
         end
         ptt_pkg::KIND_ALLOC: begin
            for (int i = 0; i < ptt_pkg::SLOTS && i < ptt_pkg::ADDR_SLOTS; i++) begin
               if (!granted && !slot_busy[i]) begin
                  granted      = 1'b1;
                  slot_busy[i] = 1'b1;
                  program_slot(i, ms);
                  r.slot_out   = 3'(i);
                  r.ok         = 1'b1;
                  grants_seen++;
               end
            end
         end
         ptt_pkg::KIND_SET: begin
            if (int'(slot) < ptt_pkg::SLOTS) begin
               program_slot(int'(slot), ms);
               r.ok = 1'b1;
            end
         end
         ptt_pkg::KIND_READ: begin
            if (int'(slot) < ptt_pkg::SLOTS) begin
               r.flag_count = slot_events[slot];
               r.ok         = 1'b1;
               if (slot_events[slot] == ptt_pkg::EVENT_MAX) saturated_reads++;
            end
         end
         ptt_pkg::KIND_CLEAR: begin
            if (int'(slot) < ptt_pkg::SLOTS) begin
               slot_events[slot] = '0;
               r.ok = 1'b1;
            end
         end
         ptt_pkg::KIND_TIME: begin
            r.time_ms = 63'(elapsed_ticks / 64'(ptt_pkg::TICKS_PER_MS));
            r.ok      = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] exp_val,
                                         input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // response checker and request predictor, both on the rising edge
   always @(posedge clock) begin
      timer_reply_type exp_reply;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               exp_reply = pending_replies.pop_front();
               compare_field("slot_out", 64'(exp_reply.slot_out), 64'(rsp_slot_out));
               compare_field("ok", 64'(exp_reply.ok), 64'(rsp_ok));
               compare_field("flag_count", 64'(exp_reply.flag_count), 64'(rsp_flag_count));
               compare_field("time_ms", 64'(exp_reply.time_ms), 64'(rsp_time_ms));
               compare_field("fire_mask", 64'(exp_reply.fire_mask), 64'(rsp_fire_mask));
               replies_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_replies.push_back(timer_bank_step(req_kind, req_slot, req_period_ms));
            requests_taken++;
         end
      end
   end

   // response side backpressure
   always @(negedge clock) begin
      rsp_stall = !quiet && ($urandom_range(0, 99) < 7);
   end

   task automatic send_request(input logic [2:0] kind, input logic [2:0] slot,
                               input logic [23:0] ms);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_kind      = kind;
      req_slot      = slot;
      req_period_ms = ms;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [23:0] random_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 24'($urandom_range(0, 6));
      if (r < 90) return 24'($urandom);
      if (r < 95) return 24'd0;
      return 24'hFFFFFF;
   endfunction

   task automatic test_reset_defaults();
      send_request(ptt_pkg::KIND_READ, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_READ, 3'd7, 24'd0);
      send_request(ptt_pkg::KIND_TIME, 3'd0, 24'd0);
      // every counter starts at zero, so the first tick reloads all slots
      send_request(ptt_pkg::KIND_TICK, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_READ, 3'd5, 24'd0);
      send_request(ptt_pkg::KIND_TICK, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_TIME, 3'd0, 24'd0);
   endtask

   task automatic test_unknown_kinds();
      send_request(3'd6, 3'd7, 24'hFFFFFF);
      send_request(3'd7, 3'd0, 24'h000001);
   endtask

   task automatic test_allocate();
      send_request(ptt_pkg::KIND_ALLOC, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_ALLOC, 3'd0, 24'hFFFFFF);
      send_request(ptt_pkg::KIND_ALLOC, 3'd0, 24'd1);
   endtask

   task automatic test_set_period();
      // free slot takes the period but stays unallocated
      send_request(ptt_pkg::KIND_SET, 3'd7, 24'd0);
      send_request(ptt_pkg::KIND_SET, 3'd1, 24'd1);
   endtask

   task automatic test_fire_mask();
      repeat (3) send_request(ptt_pkg::KIND_TICK, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_READ, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_READ, 3'd7, 24'd0);
   endtask

   task automatic test_clear_flag();
      send_request(ptt_pkg::KIND_CLEAR, 3'd0, 24'd0);
      send_request(ptt_pkg::KIND_READ, 3'd0, 24'd0);
   endtask

   task automatic test_allocate_exhaust();
      repeat (10) send_request(ptt_pkg::KIND_ALLOC, 3'($urandom), 24'($urandom_range(0, 3)));
   endtask

   task automatic test_event_saturation();
      repeat (300) send_request(ptt_pkg::KIND_TICK, 3'($urandom), 24'($urandom));
      for (int s = 0; s < 8; s++) send_request(ptt_pkg::KIND_READ, 3'(s), 24'd0);
      send_request(ptt_pkg::KIND_TIME, 3'd0, 24'd0);
   endtask

   task automatic test_random_traffic(input int count);
      int r;
      logic [2:0] kind;
      for (int n = 0; n < count; n++) begin
         quiet = (n >= 600 && n < 900);
         r = $urandom_range(0, 99);
         if (r < 45)      kind = ptt_pkg::KIND_TICK;
         else if (r < 52) kind = ptt_pkg::KIND_ALLOC;
         else if (r < 62) kind = ptt_pkg::KIND_SET;
         else if (r < 80) kind = ptt_pkg::KIND_READ;
         else if (r < 88) kind = ptt_pkg::KIND_CLEAR;
         else if (r < 96) kind = ptt_pkg::KIND_TIME;
         else             kind = 3'($urandom_range(6, 7));
         send_request(kind, 3'($urandom), random_period());
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = '0;
      req_slot      = '0;
      req_period_ms = '0;
      rsp_stall     = 1'b0;
      quiet         = 1'b0;
      fail_count    = 0;
      reset_timer_bank();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_unknown_kinds();
      test_allocate();
      test_set_period();
      test_fire_mask();
      test_clear_flag();
      test_allocate_exhaust();
      test_event_saturation();
      test_random_traffic(1500);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("took %0d requests (%0d ticks, %0d grants), checked %0d responses",
               requests_taken, ticks_seen, grants_seen, replies_checked);
      $display("saturated event counts read back %0d times", saturated_reads);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", pending_replies.size());
      $display("Verification failed");
      $finish;
   end

endmodule
